// ----- hw/rtl/rgm_pkg.sv -----
// shared types and constants for the rotated grid merge unit
// no dependencies; imported by every module of the block
package rgm_pkg;

  localparam int MAP_WIDTH      = 256;
  localparam int MAP_HEIGHT     = 256;
  localparam int LOCAL_CAPACITY = 16384;

  localparam int MAP_CELLS = MAP_WIDTH * MAP_HEIGHT;
  localparam int MAP_AW    = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
  localparam int LOCAL_AW  = (LOCAL_CAPACITY > 1) ? $clog2(LOCAL_CAPACITY) : 1;
  localparam int XW        = (MAP_WIDTH > 1) ? $clog2(MAP_WIDTH) : 1;
  localparam int MAP_DMAX  = (MAP_WIDTH > MAP_HEIGHT) ? MAP_WIDTH : MAP_HEIGHT;

  // datapath widths: centre accumulator, offset, product, rotated, diff, cell product
  localparam int CW = 25 + $clog2(2 * MAP_DMAX);
  localparam int DW = CW + 2;
  localparam int PW = DW + 16;
  localparam int RW = PW + 1 - 14;
  localparam int EW = RW + 1;
  localparam int QW = EW + 26;
  localparam int KW = QW - 32;

  typedef enum logic [1:0] {
    OP_CLEAR     = 2'd0,
    OP_LOAD      = 2'd1,
    OP_INTEGRATE = 2'd2,
    OP_READ      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_MAP_RES   = 3'd0,
    CFG_MAP_OX    = 3'd1,
    CFG_MAP_OY    = 3'd2,
    CFG_LOC_OX    = 3'd3,
    CFG_LOC_OY    = 3'd4,
    CFG_LOC_INV   = 3'd5,
    CFG_LOC_W     = 3'd6,
    CFG_LOC_H     = 3'd7
  } cfg_e;

  typedef struct packed {
    logic load_item;
    logic local_wr;
    logic map_rd;
    logic sweep_init;
    logic clear_wr;
    logic ld_dxdy;
    logic ld_prod;
    logic ld_rot;
    logic ld_diff;
    logic ld_cell;
    logic ld_local;
    logic int_wr;
    logic advance;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic last_cell;
  } dp_sts_t;

endpackage

// ----- hw/rtl/rotated_grid_merge_into_map_unit.sv -----
// top level of the rotated grid merge unit
// depends on rgm_pkg, rgm_ctrl and rgm_datapath
//
// merges a local costmap into a global occupancy map by inverse-warping every
// map cell centre into the robot frame (nearest neighbor). one result beat per
// input beat. after reset the map is swept to unknown (-1), one cell a cycle,
// over all MAP_WIDTH*MAP_HEIGHT (65536) cells, during which no input beat is
// taken; config writes are taken at any time. load and read beats go through
// the response state to the output register. clear sweeps every map cell to
// -1 first. integrate runs a seven-step sequence for every map cell, as the
// steps share one multiplier set and the single write port of the map memory.
// one item is in flight at a time; a finished result waits in the output
// register while the next beat is taken.
module rotated_grid_merge_into_map_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [15:0]        cell_index_i,
  input  logic signed [7:0]  cell_cost_i,
  input  logic signed [31:0] robot_x_i,
  input  logic signed [31:0] robot_y_i,
  input  logic signed [15:0] cos_yaw_i,
  input  logic signed [15:0] sin_yaw_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [7:0]  map_cost_o,
  output logic [1:0]         op_done_o
);
  import rgm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // config registers accept every beat
  assign cfg_ready_o = 1'b1;

  rgm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rgm_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .op_i         (op_i),
    .cell_index_i (cell_index_i),
    .cell_cost_i  (cell_cost_i),
    .robot_x_i    (robot_x_i),
    .robot_y_i    (robot_y_i),
    .cos_yaw_i    (cos_yaw_i),
    .sin_yaw_i    (sin_yaw_i),
    .map_cost_o   (map_cost_o),
    .op_done_o    (op_done_o)
  );

endmodule

// ----- hw/rtl/rgm_ctrl.sv -----
// sequencer for the rotated grid merge unit
// depends on rgm_pkg; drives rgm_datapath through dp_cmd_t
module rgm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      op_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  rgm_pkg::dp_sts_t sts_i,
  output rgm_pkg::dp_cmd_t cmd_o
);
  import rgm_pkg::*;

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_CLEAR = 4'd2;
  localparam logic [3:0] ST_D     = 4'd3;
  localparam logic [3:0] ST_M     = 4'd4;
  localparam logic [3:0] ST_R     = 4'd5;
  localparam logic [3:0] ST_O     = 4'd6;
  localparam logic [3:0] ST_C     = 4'd7;
  localparam logic [3:0] ST_L     = 4'd8;
  localparam logic [3:0] ST_W     = 4'd9;
  localparam logic [3:0] ST_RESP  = 4'd10;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.clear_wr = 1'b1;
        cmd_o.advance  = 1'b1;
        if (sts_i.last_cell) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load_item = 1'b1;
          case (op_e'(op_i))
            OP_CLEAR: begin
              cmd_o.sweep_init = 1'b1;
              state_d = ST_CLEAR;
            end
            OP_LOAD: begin
              cmd_o.local_wr = 1'b1;
              state_d = ST_RESP;
            end
            OP_INTEGRATE: begin
              cmd_o.sweep_init = 1'b1;
              state_d = ST_D;
            end
            default: begin
              cmd_o.map_rd = 1'b1;
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        cmd_o.advance  = 1'b1;
        if (sts_i.last_cell) state_d = ST_RESP;
      end
      ST_D: begin
        cmd_o.ld_dxdy = 1'b1;
        state_d = ST_M;
      end
      ST_M: begin
        cmd_o.ld_prod = 1'b1;
        state_d = ST_R;
      end
      ST_R: begin
        cmd_o.ld_rot = 1'b1;
        state_d = ST_O;
      end
      ST_O: begin
        cmd_o.ld_diff = 1'b1;
        state_d = ST_C;
      end
      ST_C: begin
        cmd_o.ld_cell = 1'b1;
        state_d = ST_L;
      end
      ST_L: begin
        cmd_o.ld_local = 1'b1;
        state_d = ST_W;
      end
      ST_W: begin
        cmd_o.int_wr  = 1'b1;
        cmd_o.advance = 1'b1;
        state_d = sts_i.last_cell ? ST_RESP : ST_D;
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hw/rtl/rgm_datapath.sv -----
// registers, map and costmap memories and per-cell arithmetic
// depends on rgm_pkg; commanded by rgm_ctrl
module rgm_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rgm_pkg::dp_cmd_t    cmd_i,
  output rgm_pkg::dp_sts_t    sts_o,
  input  logic                cfg_valid_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic [1:0]          op_i,
  input  logic [15:0]         cell_index_i,
  input  logic signed [7:0]   cell_cost_i,
  input  logic signed [31:0]  robot_x_i,
  input  logic signed [31:0]  robot_y_i,
  input  logic signed [15:0]  cos_yaw_i,
  input  logic signed [15:0]  sin_yaw_i,
  output logic signed [7:0]   map_cost_o,
  output logic [1:0]          op_done_o
);
  import rgm_pkg::*;

  logic [24:0]        res_q, inv_q;
  logic signed [31:0] mox_q, moy_q, lox_q, loy_q;
  logic [7:0]         lw_q, lh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= 25'd6554;
      mox_q <= '0;
      moy_q <= '0;
      lox_q <= '0;
      loy_q <= '0;
      inv_q <= 25'd655360;
      lw_q  <= 8'd128;
      lh_q  <= 8'd128;
    end else if (cfg_valid_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_MAP_RES: res_q <= cfg_data_i[24:0];
        CFG_MAP_OX:  mox_q <= cfg_data_i;
        CFG_MAP_OY:  moy_q <= cfg_data_i;
        CFG_LOC_OX:  lox_q <= cfg_data_i;
        CFG_LOC_OY:  loy_q <= cfg_data_i;
        CFG_LOC_INV: inv_q <= cfg_data_i[24:0];
        CFG_LOC_W:   lw_q  <= cfg_data_i[7:0];
        CFG_LOC_H:   lh_q  <= cfg_data_i[7:0];
        default:     ;
      endcase
    end
  end

  // item latch
  logic [1:0]         op_q;
  logic signed [31:0] pose_x_q, pose_y_q;
  logic signed [15:0] cos_q, sin_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q     <= op_i;
      pose_x_q <= robot_x_i;
      pose_y_q <= robot_y_i;
      cos_q    <= cos_yaw_i;
      sin_q    <= sin_yaw_i;
    end
  end

  // sweep counters: map address, column, centre accumulators (2i+1)*res
  logic [MAP_AW-1:0] addr_q;
  logic [XW-1:0]     x_q;
  logic [CW-1:0]     acc_x_q, acc_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      x_q    <= '0;
    end else if (cmd_i.sweep_init) begin
      addr_q <= '0;
      x_q    <= '0;
    end else if (cmd_i.advance) begin
      addr_q <= addr_q + 1'b1;
      x_q    <= (x_q == XW'(MAP_WIDTH - 1)) ? '0 : x_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_init) begin
      acc_x_q <= CW'(res_q);
      acc_y_q <= CW'(res_q);
    end else if (cmd_i.advance) begin
      if (x_q == XW'(MAP_WIDTH - 1)) begin
        acc_x_q <= CW'(res_q);
        acc_y_q <= acc_y_q + CW'({res_q, 1'b0});
      end else begin
        acc_x_q <= acc_x_q + CW'({res_q, 1'b0});
      end
    end
  end

  assign sts_o.last_cell = (addr_q == MAP_AW'(MAP_CELLS - 1));

  // per-cell arithmetic
  logic signed [DW-1:0] dx_q, dy_q;
  logic signed [PW-1:0] p_cdx_q, p_sdy_q, p_cdy_q, p_sdx_q;
  logic signed [PW:0]   sum_x, sum_y;
  logic signed [RW-1:0] rot_x_q, rot_y_q;
  logic signed [EW-1:0] dif_x_q, dif_y_q;
  logic signed [QW-1:0] q_x_q, q_y_q;
  logic signed [KW-1:0] cx, cy;
  logic                 in_x, in_y, hit;
  logic [16:0]          li;
  logic                 hit_q;
  logic signed [7:0]    loc_rd_q;

  assign sum_x = (PW+1)'(p_cdx_q) + (PW+1)'(p_sdy_q);
  assign sum_y = (PW+1)'(p_cdy_q) - (PW+1)'(p_sdx_q);
  assign cx    = q_x_q[QW-1:32];
  assign cy    = q_y_q[QW-1:32];
  assign in_x  = !cx[KW-1] && (cx[KW-2:8] == '0) && (cx[7:0] < lw_q);
  assign in_y  = !cy[KW-1] && (cy[KW-2:8] == '0) && (cy[7:0] < lh_q);
  assign li    = 17'({8'd0, cy[7:0]} * {8'd0, lw_q}) + 17'(cx[7:0]);
  assign hit   = in_x && in_y && (32'(li) < 32'(LOCAL_CAPACITY));

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_dxdy) begin
      dx_q <= DW'(mox_q) + DW'($signed({1'b0, acc_x_q[CW-1:1]})) - DW'(pose_x_q);
      dy_q <= DW'(moy_q) + DW'($signed({1'b0, acc_y_q[CW-1:1]})) - DW'(pose_y_q);
    end
    if (cmd_i.ld_prod) begin
      p_cdx_q <= cos_q * dx_q;
      p_sdy_q <= sin_q * dy_q;
      p_cdy_q <= cos_q * dy_q;
      p_sdx_q <= sin_q * dx_q;
    end
    if (cmd_i.ld_rot) begin
      rot_x_q <= sum_x[PW:14];
      rot_y_q <= sum_y[PW:14];
    end
    if (cmd_i.ld_diff) begin
      dif_x_q <= EW'(rot_x_q) - EW'(lox_q);
      dif_y_q <= EW'(rot_y_q) - EW'(loy_q);
    end
    if (cmd_i.ld_cell) begin
      q_x_q <= dif_x_q * $signed({1'b0, inv_q});
      q_y_q <= dif_y_q * $signed({1'b0, inv_q});
    end
  end

  // costmap memory
  logic signed [7:0] local_mem [LOCAL_CAPACITY];

  always_ff @(posedge clk_i) begin
    if (cmd_i.local_wr && (32'(cell_index_i) < 32'(LOCAL_CAPACITY))) begin
      local_mem[LOCAL_AW'(cell_index_i)] <= cell_cost_i;
    end
    if (cmd_i.ld_local) begin
      hit_q <= hit;
      if (hit) loc_rd_q <= local_mem[LOCAL_AW'(li)];
    end
  end

  // map memory, one write and one read port
  logic signed [7:0] map_mem [MAP_CELLS];
  logic signed [7:0] map_rd_q;
  logic              rd_ok_q;
  logic              map_we;
  logic signed [7:0] map_wdata;

  assign map_we    = cmd_i.clear_wr || (cmd_i.int_wr && hit_q && !loc_rd_q[7]);
  assign map_wdata = cmd_i.clear_wr ? -8'sd1 : loc_rd_q;

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[addr_q] <= map_wdata;
    if (cmd_i.map_rd) begin
      rd_ok_q <= (32'(cell_index_i) < 32'(MAP_CELLS));
      if (32'(cell_index_i) < 32'(MAP_CELLS)) map_rd_q <= map_mem[MAP_AW'(cell_index_i)];
    end
  end

  // result register
  logic signed [7:0] map_cost_q;
  logic [1:0]        op_done_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      map_cost_q <= ((op_e'(op_q) == OP_READ) && rd_ok_q) ? map_rd_q : '0;
      op_done_q  <= op_q;
    end
  end

  assign map_cost_o = map_cost_q;
  assign op_done_o  = op_done_q;

endmodule

// ----- hw/rtl/rgm_checker.sv -----
// port-level checks for the rotated grid merge unit
// depends on rgm_pkg; bound to rotated_grid_merge_into_map_unit
module rgm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         op_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [7:0]  map_cost_o,
  input logic [1:0]         op_done_o
);
  import rgm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(map_cost_o) && $stable(op_done_o))
    else $error("result beat changed while stalled");

  a_zero_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (op_done_o != OP_READ) |-> map_cost_o == 8'sd0)
    else $error("nonzero cost on a non-read result");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat taken while busy");

  a_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o && ((op_i == OP_LOAD) || (op_i == OP_READ))
    |=> ##1 out_valid_o && (op_done_o == $past(op_i, 2)))
    else $error("load or read result late or wrong");

endmodule

bind rotated_grid_merge_into_map_unit rgm_checker u_rgm_checker (.*);

// ----- tb/testbench.sv -----
// self-checking testbench for rotated_grid_merge_into_map_unit
// depends on rgm_pkg and the block's rtl; holds its own map and costmap model
`timescale 1ns / 1ps

import rgm_pkg::*;

// map and costmap model plus the queue of results still owed by the block
class merge_board;
  typedef struct {
    logic signed [7:0] cost;
    op_e               op;
  } result_t;

  byte        grid[MAP_CELLS];
  byte        costmap[LOCAL_CAPACITY];
  bit         loaded[LOCAL_CAPACITY];
  longint     map_res, map_ox, map_oy, loc_ox, loc_oy, loc_inv, loc_w, loc_h;
  result_t    owed[$];
  int         errors;

  function new();
    foreach (grid[i]) grid[i] = -1;
    map_res = 6554;
    loc_inv = 655360;
    loc_w   = 128;
    loc_h   = 128;
  endfunction

  function void configure(cfg_e idx, logic [31:0] d);
    case (idx)
      CFG_MAP_RES: map_res = d[24:0];
      CFG_MAP_OX:  map_ox  = longint'(signed'(d));
      CFG_MAP_OY:  map_oy  = longint'(signed'(d));
      CFG_LOC_OX:  loc_ox  = longint'(signed'(d));
      CFG_LOC_OY:  loc_oy  = longint'(signed'(d));
      CFG_LOC_INV: loc_inv = d[24:0];
      CFG_LOC_W:   loc_w   = d[7:0];
      default:     loc_h   = d[7:0];
    endcase
  endfunction

  // every costmap cell an integrate may touch has been loaded
  function bit costmap_ready();
    longint n;
    n = loc_w * loc_h;
    if (n > LOCAL_CAPACITY) n = LOCAL_CAPACITY;
    for (int i = 0; i < n; i++) if (!loaded[i]) return 0;
    return 1;
  endfunction

  // floor(d * inv / 2^32) with arithmetic shifts
  function longint to_cell(longint d);
    longint hi, lo;
    hi = loc_inv >> 16;
    lo = loc_inv & 64'hffff;
    return (d * hi + ((d * lo) >>> 16)) >>> 16;
  endfunction

  function void merge(longint px, longint py, longint c, longint s);
    longint dx, dy, rx, ry, cx, cy, li;
    for (int y = 0; y < MAP_HEIGHT; y++) begin
      dy = map_oy + (((2 * longint'(y) + 1) * map_res) >> 1) - py;
      for (int x = 0; x < MAP_WIDTH; x++) begin
        dx = map_ox + (((2 * longint'(x) + 1) * map_res) >> 1) - px;
        rx = (c * dx + s * dy) >>> 14;
        ry = (c * dy - s * dx) >>> 14;
        cx = to_cell(rx - loc_ox);
        cy = to_cell(ry - loc_oy);
        if (cx < 0 || cy < 0 || cx >= loc_w || cy >= loc_h) continue;
        li = cy * loc_w + cx;
        if (li >= LOCAL_CAPACITY) continue;
        if (costmap[li] >= 0) grid[y * MAP_WIDTH + x] = costmap[li];
      end
    end
  endfunction

  // accepted input beat: update the model and queue its result
  function void note_item(op_e op, logic [15:0] idx, logic signed [7:0] cost,
                          logic signed [31:0] px, logic signed [31:0] py,
                          logic signed [15:0] c, logic signed [15:0] s);
    result_t r;
    r.cost = 0;
    r.op   = op;
    case (op)
      OP_CLEAR: foreach (grid[i]) grid[i] = -1;
      OP_LOAD: if (idx < LOCAL_CAPACITY) begin
        costmap[idx] = cost;
        loaded[idx]  = 1;
      end
      OP_INTEGRATE: merge(px, py, c, s);
      default: if (idx < MAP_CELLS) r.cost = grid[idx];
    endcase
    owed.push_back(r);
  endfunction

  function void check_result(logic signed [7:0] cost, logic [1:0] op);
    result_t r;
    if (owed.size() == 0) begin
      $error("result beat with nothing expected: map_cost %0d op_done %0d", cost, op);
      errors++;
      return;
    end
    r = owed.pop_front();
    if (op !== r.op) begin
      $error("op_done: expected %0d, got %0d", r.op, op);
      errors++;
    end
    if (cost !== r.cost) begin
      $error("map_cost: expected %0d, got %0d", r.cost, cost);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               cfg_valid_i = 0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 0;
  logic               in_ready_o;
  logic [1:0]         op_i = '0;
  logic [15:0]        cell_index_i = '0;
  logic signed [7:0]  cell_cost_i = '0;
  logic signed [31:0] robot_x_i = '0;
  logic signed [31:0] robot_y_i = '0;
  logic signed [15:0] cos_yaw_i = '0;
  logic signed [15:0] sin_yaw_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 0;
  logic signed [7:0]  map_cost_o;
  logic [1:0]         op_done_o;

  merge_board board;
  // idle percentages for the sender and the receiver
  int tx_idle = 26;
  int rx_idle = 50;
  // top-left map cell of the area where the costmap is expected to land
  int hot_base = 128 * MAP_WIDTH + 128;

  rotated_grid_merge_into_map_unit i_dut (.*);

  always #4 clk_i = ~clk_i;

  // receiver: check at the edge, then pick the next ready value
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) board.check_result(map_cost_o, op_done_o);
    out_ready_i <= ($urandom_range(99) >= rx_idle);
  end

  // hard stop; a correct run needs well under a quarter of this
  initial begin
    #200_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic signed [15:0] any_trig();
    return 16'($urandom_range(32768) - 16384);
  endfunction

  // one input beat; valid only drops when a gap follows
  task automatic send_beat(op_e op, logic [15:0] idx, logic signed [7:0] cost,
                           logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [15:0] c, logic signed [15:0] s);
    int gap;
    gap = ($urandom_range(99) < tx_idle) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1;
    op_i         <= op;
    cell_index_i <= idx;
    cell_cost_i  <= cost;
    robot_x_i    <= px;
    robot_y_i    <= py;
    cos_yaw_i    <= c;
    sin_yaw_i    <= s;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(op, idx, cost, px, py, c, s);
  endtask

  task automatic load_cell(logic [15:0] idx, logic signed [7:0] cost);
    send_beat(OP_LOAD, idx, cost, $urandom, $urandom, any_trig(), any_trig());
  endtask

  task automatic read_cell(logic [15:0] idx);
    send_beat(OP_READ, idx, $urandom, $urandom, $urandom, any_trig(), any_trig());
  endtask

  task automatic clear_map();
    send_beat(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, any_trig(), any_trig());
  endtask

  task automatic merge_pose(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [15:0] c, logic signed [15:0] s);
    if (!board.costmap_ready()) begin
      $error("integrate would read unloaded costmap cells");
      board.errors++;
    end
    send_beat(OP_INTEGRATE, $urandom, $urandom, px, py, c, s);
  endtask

  // load the first n costmap cells, mostly known costs
  task automatic fill_costmap(int n);
    for (int i = 0; i < n; i++)
      load_cell(i, ($urandom_range(9) < 2) ? -$urandom_range(1, 128) : $urandom_range(127));
  endtask

  // block must be idle before a register write
  task automatic drain();
    in_valid_i <= 0;
    while (board.owed.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, logic [31:0] d);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.configure(idx, d);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  // reads near the merged area, the rest anywhere in the address space
  task automatic read_some(int n);
    repeat (n) begin
      if ($urandom_range(1)) read_cell(hot_base + $urandom_range(15) * MAP_WIDTH
                                       + $urandom_range(15));
      else read_cell($urandom);
    end
  endtask

  // mostly loads and reads, a rare clear
  task automatic random_mix(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(199);
      if (r == 0) clear_map();
      else if (r < 90) load_cell(($urandom_range(9) < 8) ? $urandom_range(LOCAL_CAPACITY - 1)
                                                         : $urandom_range(65535, LOCAL_CAPACITY),
                                 $urandom);
      else read_some(1);
    end
  endtask

  initial begin
    real a;
    board = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // phase one: sender idles sometimes, receiver often; 16x8 costmap, yaw 0
    write_reg(CFG_MAP_RES, 6554);
    write_reg(CFG_MAP_OX, 0);
    write_reg(CFG_MAP_OY, 0);
    write_reg(CFG_LOC_OX, 0);
    write_reg(CFG_LOC_OY, 0);
    write_reg(CFG_LOC_INV, 655360);
    write_reg(CFG_LOC_W, 16);
    write_reg(CFG_LOC_H, 8);

    // field extremes, ignored load, reads at both ends and past nothing
    load_cell(0, 127);
    load_cell(LOCAL_CAPACITY - 1, -128);
    load_cell(LOCAL_CAPACITY, 5);
    load_cell(16'hffff, 9);
    read_cell(0);
    read_cell(16'hffff);
    clear_map();
    read_cell(1);
    fill_costmap(128);
    merge_pose(32'd838861, 32'd838861, 16384, 0);
    read_cell(hot_base);
    read_cell(hot_base + 7 * MAP_WIDTH + 15);
    read_some(8);
    random_mix(270);
    drain();

    // phase two: roles swapped; register extremes
    tx_idle = 50;
    rx_idle = 26;
    write_reg(CFG_MAP_RES, 25'h1000000);
    write_reg(CFG_MAP_OX, 32'h8000_0000);
    write_reg(CFG_MAP_OY, 32'h7fff_ffff);
    write_reg(CFG_LOC_OX, $urandom);
    write_reg(CFG_LOC_OY, $urandom);
    write_reg(CFG_LOC_INV, 1);
    write_reg(CFG_LOC_W, 128);
    write_reg(CFG_LOC_H, 1);
    fill_costmap(128);
    merge_pose(32'h8000_0000, 32'h7fff_ffff, -16384, 16384);
    read_some(20);
    random_mix(120);
    drain();

    // zero width and zero resolutions: nothing may land
    write_reg(CFG_MAP_RES, 0);
    write_reg(CFG_LOC_INV, 0);
    write_reg(CFG_LOC_W, 0);
    write_reg(CFG_LOC_H, 128);
    merge_pose(32'h7fff_ffff, 32'h8000_0000, 16384, -16384);
    random_mix(120);
    drain();

    // phase three: no idling; random pose and costmap near the map centre
    tx_idle = 0;
    rx_idle = 0;
    a = $urandom_range(6283) / 1000.0;
    write_reg(CFG_MAP_RES, 6554);
    write_reg(CFG_MAP_OX, 0);
    write_reg(CFG_MAP_OY, 0);
    write_reg(CFG_LOC_OX, -$urandom_range(65536));
    write_reg(CFG_LOC_OY, -$urandom_range(65536));
    write_reg(CFG_LOC_INV, $urandom_range(327680, 983040));
    write_reg(CFG_LOC_W, $urandom_range(4, 16));
    write_reg(CFG_LOC_H, $urandom_range(4, 12));
    hot_base = 120 * MAP_WIDTH + 120;
    fill_costmap(board.loc_w * board.loc_h);
    merge_pose(32'd838861 + $urandom_range(131072) - 65536,
               32'd838861 + $urandom_range(131072) - 65536,
               $rtoi(16384.0 * $cos(a)), $rtoi(16384.0 * $sin(a)));
    read_some(30);
    random_mix(250);
    drain();

    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.owed.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
